/* rtl/core/ffrm_pkg.sv */
package ffrm_pkg;

   localparam int ADDR_BITS        = 24;
   localparam int DEF_MAP_ENTRIES  = 64;
   localparam int LIMIT_BITS       = 6;
   localparam int SLOTS_BITS       = 7;
   localparam int CSR_ADDR_BITS    = 3;
   localparam int CSR_DATA_BITS    = 32;

   localparam logic [LIMIT_BITS-1:0] SLOT_LIMIT_RESET = 6'd63;
   localparam logic [SLOTS_BITS-1:0] SLOTS_MAX        = 7'd127;
   localparam logic [ADDR_BITS-1:0]  LEN_MAX          = {ADDR_BITS{1'b1}};

   // command codes
   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE  = 2'd1;
   localparam logic [1:0] CMD_MARK  = 2'd2;

   // register index (word address bit)
   localparam logic REG_SLOT_LIMIT = 1'b0;

   typedef struct packed {
      logic [ADDR_BITS-1:0] base;
      logic [ADDR_BITS-1:0] len;
   } extent_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_RD,
      OP_IDX_INC,
      OP_A_TRIM,
      OP_A_TAKE,
      OP_F_STEP,
      OP_F_MPREV,
      OP_F_MBOTH,
      OP_F_MNEXT,
      OP_F_LOST,
      OP_I_INIT,
      OP_I_RD,
      OP_I_WR,
      OP_I_PUT,
      OP_R_RD,
      OP_R_WR,
      OP_R_END,
      OP_WAKE,
      OP_MARK,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       scan_end;
      logic       hit;
      logic       trim_zero;
      logic       past;
      logic       has_prev;
      logic       has_next;
      logic       prev_adj;
      logic       next_adj;
      logic       size_zero;
      logic       full;
      logic       up_more;
      logic       down_more;
      logic       out_free;
   } dp_status_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_A_RD,
      ST_A_CHK,
      ST_F_RD,
      ST_F_CHK,
      ST_F_DEC,
      ST_R_LOOP,
      ST_R_WR,
      ST_I_LOOP,
      ST_I_WR,
      ST_F_WAKE,
      ST_FINISH
   } state_type;

   function automatic logic [ADDR_BITS-1:0] sat_len(input logic [ADDR_BITS+1:0] s);
      logic [ADDR_BITS-1:0] r;
      r = (s > {2'b00, LEN_MAX}) ? LEN_MAX : s[ADDR_BITS-1:0];
      return r;
   endfunction

endpackage

/* rtl/core/first_fit_resource_map_top.sv */
// Channel  Direction  Handshake            Beat contents
// req      in         req_valid/req_stall  command, unit_count, base_address
// rsp      out        rsp_valid/rsp_stall  alloc_base, alloc_ok, lost_on_overflow,
//                                          wake_waiters
// csr      in/out     APB, pready tied 1   slot_limit at byte address 0
//
// One command at a time. An allocate scans extents in order and, when an extent
// is used up, moves the later extents down; a free scans extents in order and
// moves extents up on insert or down on a double merge. The pace is set by the
// single-port extent memory, one access a cycle with registered read data, and
// by any rsp stall.
// Reset is synchronous: empty table, slot_limit 63, waiter mark clear; the
// memory needs no clearing pass, only entries below the live count are read.
// req_stall is high while a command is in work; a finished beat waits in the
// rsp register, and a new request is taken while it waits.
module first_fit_resource_map_top #(
   parameter int MAP_ENTRIES = ffrm_pkg::DEF_MAP_ENTRIES
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_command,
   input  logic [ffrm_pkg::ADDR_BITS-1:0]     req_unit_count,
   input  logic [ffrm_pkg::ADDR_BITS-1:0]     req_base_address,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ffrm_pkg::ADDR_BITS-1:0]     rsp_alloc_base,
   output logic                               rsp_alloc_ok,
   output logic                               rsp_lost_on_overflow,
   output logic                               rsp_wake_waiters,
   // register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ffrm_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [ffrm_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [ffrm_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);
   import ffrm_pkg::*;

   dp_op_type     op;     // one datapath command per cycle
   dp_status_type status; // compares and loop conditions back to the FSM

   // no wait states on the register port
   assign csr_pready = 1'b1;

   ffrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .op        (op)
   );

   // extent memory, scan/shift pointers, slot accounting, rsp register
   ffrm_datapath #(
      .MAP_ENTRIES (MAP_ENTRIES)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .op                   (op),
      .status               (status),
      .req_command          (req_command),
      .req_unit_count       (req_unit_count),
      .req_base_address     (req_base_address),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_alloc_base       (rsp_alloc_base),
      .rsp_alloc_ok         (rsp_alloc_ok),
      .rsp_lost_on_overflow (rsp_lost_on_overflow),
      .rsp_wake_waiters     (rsp_wake_waiters)
   );

endmodule

/* rtl/core/ffrm_datapath.sv */
module ffrm_datapath #(
   parameter int MAP_ENTRIES = ffrm_pkg::DEF_MAP_ENTRIES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ffrm_pkg::dp_op_type                  op,
   output ffrm_pkg::dp_status_type              status,
   input  logic [1:0]                           req_command,
   input  logic [ffrm_pkg::ADDR_BITS-1:0]       req_unit_count,
   input  logic [ffrm_pkg::ADDR_BITS-1:0]       req_base_address,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ffrm_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [ffrm_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [ffrm_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ffrm_pkg::ADDR_BITS-1:0]       rsp_alloc_base,
   output logic                                 rsp_alloc_ok,
   output logic                                 rsp_lost_on_overflow,
   output logic                                 rsp_wake_waiters
);
   import ffrm_pkg::*;

   localparam int AW   = $clog2(MAP_ENTRIES);
   localparam int CW   = $clog2(MAP_ENTRIES + 1);
   localparam int CMPW = (CW > SLOTS_BITS) ? CW : SLOTS_BITS;

   extent_type mem [MAP_ENTRIES];
   extent_type rdata_ff;

   logic                 mem_re, mem_we;
   logic [AW-1:0]        mem_raddr, mem_waddr;
   extent_type           mem_wdata;

   logic [1:0]           cmd_ff, cmd_in;
   logic [ADDR_BITS-1:0] size_ff, size_in, a_ff, a_in;
   logic [CW-1:0]        idx_ff, idx_in, ptr_ff, ptr_in, count_ff, count_in;
   logic [CW-1:0]        idx_m1, ptr_m1, ptr_p1;
   logic [SLOTS_BITS-1:0] slots_ff, slots_in;
   logic [LIMIT_BITS-1:0] limit_ff, limit_in;
   logic                 mark_ff, mark_in;
   extent_type           prev_ff, prev_in;
   logic                 prev_valid_ff, prev_valid_in;
   logic [ADDR_BITS-1:0] res_base_ff, res_base_in;
   logic                 res_ok_ff, res_ok_in, res_lost_ff, res_lost_in;
   logic                 res_wake_ff, res_wake_in;
   logic                 out_valid_ff, out_valid_in;
   logic [ADDR_BITS-1:0] out_base_ff, out_base_in;
   logic                 out_ok_ff, out_ok_in, out_lost_ff, out_lost_in;
   logic                 out_wake_ff, out_wake_in;

   logic [ADDR_BITS+1:0] sum_prev, sum_both, sum_next;
   logic [CMPW-1:0]      limit_x, count_x, new_limit_x;
   logic                 csr_wr;

   assign idx_m1 = idx_ff - CW'(1);
   assign ptr_m1 = ptr_ff - CW'(1);
   assign ptr_p1 = ptr_ff + CW'(1);

   assign sum_prev = {2'b00, prev_ff.len} + {2'b00, size_ff};
   assign sum_both = sum_prev + {2'b00, rdata_ff.len};
   assign sum_next = {2'b00, rdata_ff.len} + {2'b00, size_ff};

   assign csr_wr      = csr_psel && csr_penable && csr_pwrite
                        && (csr_paddr[2] == REG_SLOT_LIMIT);
   assign count_x     = CMPW'(count_ff);
   assign new_limit_x = CMPW'(csr_pwdata[LIMIT_BITS-1:0]);
   assign limit_x     = CMPW'(limit_ff);
   assign csr_prdata  = CSR_DATA_BITS'(limit_x[LIMIT_BITS-1:0]);

   always_comb begin
      cmd_in        = cmd_ff;
      size_in       = size_ff;
      a_in          = a_ff;
      idx_in        = idx_ff;
      ptr_in        = ptr_ff;
      count_in      = count_ff;
      slots_in      = slots_ff;
      limit_in      = limit_ff;
      mark_in       = mark_ff;
      prev_in       = prev_ff;
      prev_valid_in = prev_valid_ff;
      res_base_in   = res_base_ff;
      res_ok_in     = res_ok_ff;
      res_lost_in   = res_lost_ff;
      res_wake_in   = res_wake_ff;
      out_valid_in  = out_valid_ff;
      out_base_in   = out_base_ff;
      out_ok_in     = out_ok_ff;
      out_lost_in   = out_lost_ff;
      out_wake_in   = out_wake_ff;
      mem_re        = 1'b0;
      mem_raddr     = idx_ff[AW-1:0];
      mem_we        = 1'b0;
      mem_waddr     = idx_ff[AW-1:0];
      mem_wdata     = rdata_ff;

      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      case (op)
         OP_LOAD: begin
            cmd_in        = req_command;
            size_in       = req_unit_count;
            a_in          = req_base_address;
            idx_in        = '0;
            prev_valid_in = 1'b0;
            res_base_in   = '0;
            res_ok_in     = 1'b0;
            res_lost_in   = 1'b0;
            res_wake_in   = 1'b0;
         end
         OP_RD: begin
            mem_re = 1'b1;
         end
         OP_IDX_INC: begin
            idx_in = idx_ff + CW'(1);
         end
         OP_A_TRIM: begin
            res_base_in    = rdata_ff.base;
            res_ok_in      = 1'b1;
            mem_we         = 1'b1;
            mem_wdata.base = rdata_ff.base + size_ff;
            mem_wdata.len  = rdata_ff.len - size_ff;
         end
         OP_A_TAKE: begin
            res_base_in = rdata_ff.base;
            res_ok_in   = 1'b1;
            ptr_in      = idx_ff;
         end
         OP_F_STEP: begin
            prev_in       = rdata_ff;
            prev_valid_in = 1'b1;
            idx_in        = idx_ff + CW'(1);
         end
         OP_F_MPREV: begin
            mem_we         = 1'b1;
            mem_waddr      = idx_m1[AW-1:0];
            mem_wdata.base = prev_ff.base;
            mem_wdata.len  = sat_len(sum_prev);
         end
         OP_F_MBOTH: begin
            mem_we         = 1'b1;
            mem_waddr      = idx_m1[AW-1:0];
            mem_wdata.base = prev_ff.base;
            mem_wdata.len  = sat_len(sum_both);
            ptr_in         = idx_ff;
         end
         OP_F_MNEXT: begin
            mem_we         = 1'b1;
            mem_wdata.base = a_ff;
            mem_wdata.len  = sat_len(sum_next);
         end
         OP_F_LOST: begin
            res_lost_in = 1'b1;
         end
         OP_I_INIT: begin
            ptr_in = count_ff;
         end
         OP_I_RD: begin
            mem_re    = 1'b1;
            mem_raddr = ptr_m1[AW-1:0];
         end
         OP_I_WR: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff[AW-1:0];
            ptr_in    = ptr_m1;
         end
         OP_I_PUT: begin
            mem_we         = 1'b1;
            mem_wdata.base = a_ff;
            mem_wdata.len  = size_ff;
            count_in       = count_ff + CW'(1);
            slots_in       = slots_ff - SLOTS_BITS'(1);
         end
         OP_R_RD: begin
            mem_re    = 1'b1;
            mem_raddr = ptr_p1[AW-1:0];
         end
         OP_R_WR: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff[AW-1:0];
            ptr_in    = ptr_p1;
         end
         OP_R_END: begin
            count_in = count_ff - CW'(1);
            if (slots_ff != SLOTS_MAX) begin
               slots_in = slots_ff + SLOTS_BITS'(1);
            end
         end
         OP_WAKE: begin
            if (mark_ff) begin
               mark_in     = 1'b0;
               res_wake_in = 1'b1;
            end
         end
         OP_MARK: begin
            mark_in = 1'b1;
         end
         OP_OUT: begin
            out_valid_in = 1'b1;
            out_base_in  = res_base_ff;
            out_ok_in    = res_ok_ff;
            out_lost_in  = res_lost_ff;
            out_wake_in  = res_wake_ff;
         end
         default: begin
         end
      endcase

      if (csr_wr) begin
         limit_in = csr_pwdata[LIMIT_BITS-1:0];
         slots_in = (new_limit_x > count_x) ? SLOTS_BITS'(new_limit_x - count_x) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         slots_ff      <= SLOTS_BITS'(SLOT_LIMIT_RESET);
         limit_ff      <= SLOT_LIMIT_RESET;
         mark_ff       <= 1'b0;
         prev_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         slots_ff      <= slots_in;
         limit_ff      <= limit_in;
         mark_ff       <= mark_in;
         prev_valid_ff <= prev_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      cmd_ff      <= cmd_in;
      size_ff     <= size_in;
      a_ff        <= a_in;
      idx_ff      <= idx_in;
      ptr_ff      <= ptr_in;
      prev_ff     <= prev_in;
      res_base_ff <= res_base_in;
      res_ok_ff   <= res_ok_in;
      res_lost_ff <= res_lost_in;
      res_wake_ff <= res_wake_in;
      out_base_ff <= out_base_in;
      out_ok_ff   <= out_ok_in;
      out_lost_ff <= out_lost_in;
      out_wake_ff <= out_wake_in;
   end

   always_comb begin
      status.cmd       = cmd_ff;
      status.scan_end  = (idx_ff == count_ff);
      status.hit       = (rdata_ff.len >= size_ff);
      status.trim_zero = (rdata_ff.len == size_ff);
      status.past      = (rdata_ff.base > a_ff);
      status.has_prev  = prev_valid_ff;
      status.has_next  = (idx_ff != count_ff);
      status.prev_adj  = (({1'b0, prev_ff.base} + {1'b0, prev_ff.len}) == {1'b0, a_ff});
      status.next_adj  = (({1'b0, a_ff} + {1'b0, size_ff}) == {1'b0, rdata_ff.base});
      status.size_zero = (size_ff == '0);
      status.full      = (slots_ff == '0) || (count_ff == CW'(MAP_ENTRIES));
      status.up_more   = (ptr_ff > idx_ff);
      status.down_more = (({1'b0, ptr_ff} + (CW+1)'(1)) < {1'b0, count_ff});
      status.out_free  = !out_valid_ff || !rsp_stall;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_alloc_base       = out_base_ff;
   assign rsp_alloc_ok         = out_ok_ff;
   assign rsp_lost_on_overflow = out_lost_ff;
   assign rsp_wake_waiters     = out_wake_ff;

endmodule

/* rtl/core/ffrm_ctrl.sv */
module ffrm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  ffrm_pkg::dp_status_type status,
   output ffrm_pkg::dp_op_type     op
);
   import ffrm_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      op        = OP_NONE;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op       = OP_LOAD;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (status.cmd)
               CMD_ALLOC: state_in = ST_A_RD;
               CMD_FREE:  state_in = ST_F_RD;
               CMD_MARK: begin
                  op       = OP_MARK;
                  state_in = ST_FINISH;
               end
               default:   state_in = ST_FINISH;
            endcase
         end
         ST_A_RD: begin
            if (status.scan_end) begin
               state_in = ST_FINISH;
            end else begin
               op       = OP_RD;
               state_in = ST_A_CHK;
            end
         end
         ST_A_CHK: begin
            if (status.hit && status.trim_zero) begin
               op       = OP_A_TAKE;
               state_in = ST_R_LOOP;
            end else if (status.hit) begin
               op       = OP_A_TRIM;
               state_in = ST_FINISH;
            end else begin
               op       = OP_IDX_INC;
               state_in = ST_A_RD;
            end
         end
         ST_F_RD: begin
            if (status.scan_end) begin
               state_in = ST_F_DEC;
            end else begin
               op       = OP_RD;
               state_in = ST_F_CHK;
            end
         end
         ST_F_CHK: begin
            if (status.past) begin
               state_in = ST_F_DEC;
            end else begin
               op       = OP_F_STEP;
               state_in = ST_F_RD;
            end
         end
         ST_F_DEC: begin
            if (status.has_prev && status.prev_adj) begin
               if (status.has_next && status.next_adj) begin
                  op       = OP_F_MBOTH;
                  state_in = ST_R_LOOP;
               end else begin
                  op       = OP_F_MPREV;
                  state_in = ST_F_WAKE;
               end
            end else if (status.has_next && status.next_adj) begin
               op       = OP_F_MNEXT;
               state_in = ST_F_WAKE;
            end else if (status.size_zero) begin
               state_in = ST_F_WAKE;
            end else if (status.full) begin
               op       = OP_F_LOST;
               state_in = ST_FINISH;
            end else begin
               op       = OP_I_INIT;
               state_in = ST_I_LOOP;
            end
         end
         ST_R_LOOP: begin
            if (status.down_more) begin
               op       = OP_R_RD;
               state_in = ST_R_WR;
            end else begin
               op       = OP_R_END;
               state_in = (status.cmd == CMD_FREE) ? ST_F_WAKE : ST_FINISH;
            end
         end
         ST_R_WR: begin
            op       = OP_R_WR;
            state_in = ST_R_LOOP;
         end
         ST_I_LOOP: begin
            if (status.up_more) begin
               op       = OP_I_RD;
               state_in = ST_I_WR;
            end else begin
               op       = OP_I_PUT;
               state_in = ST_F_WAKE;
            end
         end
         ST_I_WR: begin
            op       = OP_I_WR;
            state_in = ST_I_LOOP;
         end
         ST_F_WAKE: begin
            op       = OP_WAKE;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               op       = OP_OUT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/core/ffrm_checker.sv */
module ffrm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [ffrm_pkg::ADDR_BITS-1:0] rsp_alloc_base,
   input logic                           rsp_alloc_ok,
   input logic                           rsp_lost_on_overflow,
   input logic                           rsp_wake_waiters
);
   import ffrm_pkg::*;

   a_rst_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp beat right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_alloc_base)
      && $stable(rsp_alloc_ok) && $stable(rsp_lost_on_overflow)
      && $stable(rsp_wake_waiters))
      else $error("stalled rsp beat changed");

   a_ok_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_alloc_ok |-> !rsp_lost_on_overflow && !rsp_wake_waiters)
      else $error("allocate beat carries free flags");

   a_base_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_alloc_ok |-> rsp_alloc_base == '0)
      else $error("base without ok");

   a_lost_no_wake: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_lost_on_overflow |-> !rsp_wake_waiters)
      else $error("dropped free woke waiters");

endmodule

bind first_fit_resource_map_top ffrm_checker u_ffrm_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_alloc_base       (rsp_alloc_base),
   .rsp_alloc_ok         (rsp_alloc_ok),
   .rsp_lost_on_overflow (rsp_lost_on_overflow),
   .rsp_wake_waiters     (rsp_wake_waiters)
);

/* dv/tb_first_fit_resource_map_top.sv */
`timescale 1ns / 1ps

module tb_first_fit_resource_map_top;
   import ffrm_pkg::*;

   localparam int ENTRIES      = DEF_MAP_ENTRIES;
   localparam int IDLE_LIMIT   = 20000;   // cycles with no beat before giving up
   localparam int DRAIN_CYCLES = 4 * ENTRIES + 20;

   typedef struct packed {
      logic [1:0]           cmd;
      logic [ADDR_BITS-1:0] count;
      logic [ADDR_BITS-1:0] base;
   } req_beat_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] base;
      logic                 ok;
      logic                 lost;
      logic                 wake;
   } rsp_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_command = '0;
   logic [ADDR_BITS-1:0] req_unit_count = '0;
   logic [ADDR_BITS-1:0] req_base_address = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [ADDR_BITS-1:0] rsp_alloc_base;
   logic rsp_alloc_ok, rsp_lost_on_overflow, rsp_wake_waiters;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   first_fit_resource_map_top uut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Free-extent table mirror: sorted by base, ends at first zero length.
   // ---------------------------------------------------------------------
   logic [ADDR_BITS-1:0]  ext_base [ENTRIES];
   logic [ADDR_BITS-1:0]  ext_len  [ENTRIES];
   logic [LIMIT_BITS-1:0] limit_reg;
   int                    free_slots;
   logic                  waiting;

   req_beat_type pending_reqs[$];
   rsp_beat_type expected_rsps[$];

   int  fails = 0;
   int  reqs_sent = 0, rsps_seen = 0;
   int  n_ok = 0, n_lost = 0, n_wake = 0;
   bit  stimulus_done = 0;
   int  hold_off = 0;   // long receiver hold-off, counted by the monitor

   function automatic int live_count();
      for (int i = 0; i < ENTRIES; i++)
         if (ext_len[i] == '0) return i;
      return ENTRIES;
   endfunction

   function automatic logic [ADDR_BITS-1:0] clamp_len(logic [ADDR_BITS:0] s);
      return s > {1'b0, LEN_MAX} ? LEN_MAX : s[ADDR_BITS-1:0];
   endfunction

   function automatic void drop_entry(int idx, int n);
      for (int i = idx; i + 1 < n; i++) begin
         ext_base[i] = ext_base[i+1];
         ext_len[i]  = ext_len[i+1];
      end
      if (n > 0) begin
         ext_base[n-1] = '0;
         ext_len[n-1]  = '0;
      end
   endfunction

   function automatic void mirror_reset();
      for (int i = 0; i < ENTRIES; i++) begin
         ext_base[i] = '0;
         ext_len[i]  = '0;
      end
      limit_reg  = SLOT_LIMIT_RESET;
      free_slots = SLOT_LIMIT_RESET;
      waiting    = 1'b0;
   endfunction

   function automatic void mirror_set_limit(logic [LIMIT_BITS-1:0] v);
      int n;
      n = live_count();
      limit_reg  = v;
      free_slots = (int'(v) > n) ? int'(v) - n : 0;
   endfunction

   function automatic rsp_beat_type predict_map(req_beat_type r);
      rsp_beat_type o;
      int n, i;
      logic [ADDR_BITS:0] fin;
      bit next_ok, dropped;
      o = '0;
      n = live_count();
      dropped = 0;
      case (r.cmd)
         CMD_ALLOC: begin
            for (i = 0; i < n; i++)
               if (ext_len[i] >= r.count) begin
                  o.base = ext_base[i];
                  o.ok   = 1'b1;
                  ext_base[i] = ext_base[i] + r.count;
                  ext_len[i]  = ext_len[i] - r.count;
                  if (ext_len[i] == '0) begin
                     drop_entry(i, n);
                     if (free_slots < 127) free_slots++;
                  end
                  break;
               end
         end
         CMD_FREE: begin
            fin = {1'b0, r.base} + r.count;
            i = 0;
            while (i < n && ext_base[i] <= r.base) i++;
            next_ok = (i < n) && (fin == {1'b0, ext_base[i]});
            if (i > 0 && ({1'b0, ext_base[i-1]} + ext_len[i-1]) == {1'b0, r.base}) begin
               ext_len[i-1] = clamp_len({1'b0, ext_len[i-1]} + r.count);
               if (next_ok) begin
                  ext_len[i-1] = clamp_len({1'b0, ext_len[i-1]} + ext_len[i]);
                  drop_entry(i, n);
                  if (free_slots < 127) free_slots++;
               end
            end else if (next_ok) begin
               ext_base[i] = r.base;
               ext_len[i]  = clamp_len({1'b0, ext_len[i]} + r.count);
            end else if (r.count != '0) begin
               if (free_slots == 0 || n >= ENTRIES) begin
                  dropped = 1;
                  o.lost  = 1'b1;
               end else begin
                  for (int j = n; j > i; j--) begin
                     ext_base[j] = ext_base[j-1];
                     ext_len[j]  = ext_len[j-1];
                  end
                  ext_base[i] = r.base;
                  ext_len[i]  = r.count;
                  free_slots--;
               end
            end
            if (!dropped && waiting) begin
               waiting = 1'b0;
               o.wake  = 1'b1;
            end
         end
         CMD_MARK: waiting = 1'b1;
         default: ;
      endcase
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: one beat from the queue at a time, a random gap before some of them.
   // ---------------------------------------------------------------------
   int req_gap = 0;
   logic req_stall_q = 1'b1;   // req_stall at the last rising edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_stall_q) begin
         // beat taken at the last rising edge
         if (pending_reqs.size() > 0 && req_gap == 0 && $urandom_range(0, 5) == 0) begin
            req_gap <= $urandom_range(1, 5);
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0 && req_gap == 0) begin
            req_command      <= pending_reqs[0].cmd;
            req_unit_count   <= pending_reqs[0].count;
            req_base_address <= pending_reqs[0].base;
            void'(pending_reqs.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end else if (!req_valid) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
         end else if (pending_reqs.size() > 0) begin
            req_valid        <= 1'b1;
            req_command      <= pending_reqs[0].cmd;
            req_unit_count   <= pending_reqs[0].count;
            req_base_address <= pending_reqs[0].base;
            void'(pending_reqs.pop_front());
         end
      end
   end

   // Handshake sampled at the rising edge, remembered for the driver
   always @(posedge clock) begin
      req_stall_q <= req_stall;
      if (!reset && req_valid && !req_stall) begin
         expected_rsps.push_back(predict_map('{req_command, req_unit_count,
                                               req_base_address}));
         reqs_sent++;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: checks each response beat, draws the receiver stalls.
   // ---------------------------------------------------------------------
   int rsp_gap = 0;
   int quiet = 0;
   always @(posedge clock) begin
      rsp_beat_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_alloc_base, rsp_alloc_ok, rsp_lost_on_overflow, rsp_wake_waiters};
         rsps_seen++;
         if (expected_rsps.size() == 0) begin
            $display("%0t: response beat with nothing expected: %p", $realtime, got);
            fails++;
         end else begin
            want = expected_rsps.pop_front();
            if (got.base !== want.base) begin
               $display("%0t: alloc_base exp %h got %h", $realtime, want.base, got.base);
               fails++;
            end
            if (got.ok !== want.ok) begin
               $display("%0t: alloc_ok exp %b got %b", $realtime, want.ok, got.ok);
               fails++;
            end
            if (got.lost !== want.lost) begin
               $display("%0t: lost_on_overflow exp %b got %b", $realtime, want.lost,
                        got.lost);
               fails++;
            end
            if (got.wake !== want.wake) begin
               $display("%0t: wake_waiters exp %b got %b", $realtime, want.wake,
                        got.wake);
               fails++;
            end
            n_ok   += want.ok;
            n_lost += want.lost;
            n_wake += want.wake;
         end
      end
      // watchdog: no beat on either channel
      if (!reset && !(rsp_valid && !rsp_stall) && !(req_valid && !req_stall))
         quiet <= quiet + 1;
      else
         quiet <= 0;
      if (quiet >= IDLE_LIMIT) begin
         $display("%0t: watchdog, no beat for %0d cycles", $realtime, quiet);
         $display("tb_first_fit_resource_map_top failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off  <= hold_off - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_gap > 0) begin
         rsp_gap   <= rsp_gap - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         // a beat just went; draw the stall for the next one
         rsp_gap   <= $urandom_range(0, 3) == 0 ? $urandom_range(1, 5) : 0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Register access and stimulus
   // ---------------------------------------------------------------------
   task automatic csr_write(logic [LIMIT_BITS-1:0] v);
      @(negedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= '0;   // slot_limit, register index 0
      csr_pwdata <= {{(CSR_DATA_BITS-LIMIT_BITS){1'b0}}, v};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      mirror_set_limit(v);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic void queue_req(logic [1:0] c, logic [ADDR_BITS-1:0] n,
                                     logic [ADDR_BITS-1:0] b);
      pending_reqs.push_back('{c, n, b});
   endfunction

   // slot limit for each random phase, the extremes among them
   function automatic logic [LIMIT_BITS-1:0] phase_limit(int p);
      case (p)
         0:       return 6'd63;
         1:       return 6'd3;
         2:       return 6'd1;
         3:       return 6'd20;
         default: return 6'd63;
      endcase
   endfunction

   // Mostly small aligned regions inside a narrow window so that merges,
   // splits and exact fits happen often.
   function automatic void queue_random_req(int span);
      int r;
      logic [ADDR_BITS-1:0] b, n;
      r = $urandom_range(0, 99);
      b = ADDR_BITS'($urandom_range(0, span - 1) * 16);
      n = $urandom_range(0, 3) == 0 ? ADDR_BITS'($urandom_range(1, 64))
                                    : ADDR_BITS'(16 * $urandom_range(1, 4));
      if (r < 2) begin
         queue_req(2'd3, ADDR_BITS'($urandom), ADDR_BITS'($urandom));   // unused code
      end else if (r < 5) begin
         queue_req(2'($urandom_range(0, 1)), ADDR_BITS'($urandom),
                   ADDR_BITS'($urandom));                               // wide noise
      end else if (r < 10) begin
         queue_req(CMD_MARK, ADDR_BITS'($urandom), ADDR_BITS'($urandom));
      end else if (r < 50) begin
         queue_req(CMD_ALLOC, n, ADDR_BITS'($urandom));
      end else begin
         queue_req(CMD_FREE, n, b);
      end
   endfunction

   initial begin
      mirror_reset();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty table, edges, merges, saturation, drop on full
      queue_req(CMD_ALLOC, '0, '0);                   // empty table
      queue_req(CMD_MARK, LEN_MAX, LEN_MAX);
      queue_req(CMD_FREE, '0, 24'h000100);            // zero length free wakes
      queue_req(CMD_FREE, 24'h000100, 24'h001000);
      queue_req(CMD_FREE, 24'h000100, 24'h000f00);    // merge into next
      queue_req(CMD_FREE, 24'h000100, 24'h001100);    // merge into previous
      queue_req(CMD_FREE, 24'h000100, 24'h001300);
      queue_req(CMD_FREE, 24'h000100, 24'h001200);    // merge both sides
      queue_req(CMD_ALLOC, '0, '0);                   // zero length allocate
      queue_req(CMD_ALLOC, 24'h000500, '0);           // exact fit, removes entry
      queue_req(CMD_FREE, LEN_MAX, 24'h000000);
      queue_req(CMD_FREE, LEN_MAX, LEN_MAX);          // end past the top, no wrap
      queue_req(CMD_FREE, 24'h000010, 24'hfffff0);
      queue_req(CMD_ALLOC, LEN_MAX, '0);
      queue_req(CMD_ALLOC, 24'h000001, '0);
      queue_req(CMD_FREE, LEN_MAX, 24'h000000);
      queue_req(CMD_FREE, 24'h000001, LEN_MAX);       // saturating merge
      queue_req(CMD_ALLOC, LEN_MAX, '0);
      queue_req(2'd3, LEN_MAX, LEN_MAX);
      wait_idle();

      // tight slot limit: overflow drops, and a drop keeps the waiter mark
      csr_write(6'd1);
      queue_req(CMD_FREE, 24'h10, 24'h500);
      queue_req(CMD_MARK, '0, '0);
      queue_req(CMD_FREE, 24'h10, 24'h700);
      queue_req(CMD_FREE, 24'h10, 24'h510);
      queue_req(CMD_ALLOC, 24'h20, '0);
      wait_idle();

      // random phases over several limits
      for (int p = 0; p < 5; p++) begin
         csr_write(phase_limit(p));
         for (int k = 0; k < 180; k++) queue_random_req(p == 4 ? 256 : 48);
         if (p == 2) begin
            // receiver holds off while the sender keeps offering beats
            hold_off = 400;
         end
         wait_idle();
      end
      stimulus_done = 1;

      $display("%0d requests, %0d responses: %0d allocations fitted, %0d frees lost,",
               reqs_sent, rsps_seen, n_ok, n_lost);
      $display("%0d waiter wakes; slot limits 1, 3, 20 and 63 used", n_wake);
      if (fails == 0 && expected_rsps.size() == 0)
         $display("tb_first_fit_resource_map_top passed");
      else
         $display("tb_first_fit_resource_map_top failed");
      $finish;
   end

endmodule

/* first_fit_resource_map_top.f */
rtl/core/ffrm_pkg.sv
rtl/core/ffrm_datapath.sv
rtl/core/ffrm_ctrl.sv
rtl/core/first_fit_resource_map_top.sv
rtl/core/ffrm_checker.sv
dv/tb_first_fit_resource_map_top.sv
